### rtl/rgpc_pkg.sv
// Shared types, register codes and widths of the ray ground point classifier.
package rgpc_pkg;

  localparam int RADIUS_W = 18;
  localparam int HEIGHT_W = 16;
  localparam int INDEX_W = 17;
  localparam int SENSOR_W = 13;
  localparam int DIST_W = 12;
  localparam int RECLASS_W = 16;
  localparam int TAN_W = 16;
  localparam int FRAC_W = 16;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register codes, taken from paddr[4:2]
  localparam logic [2:0] REG_MOUNT_HEIGHT = 3'd0;
  localparam logic [2:0] REG_MIN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CONCENTRIC = 3'd2;
  localparam logic [2:0] REG_RECLASS = 3'd3;
  localparam logic [2:0] REG_LOCAL_TAN = 3'd4;
  localparam logic [2:0] REG_GENERAL_TAN = 3'd5;

  localparam logic [SENSOR_W-1:0] MOUNT_HEIGHT_RST = 13'd300;
  localparam logic [DIST_W-1:0] MIN_HEIGHT_RST = 12'd50;
  localparam logic [DIST_W-1:0] CONCENTRIC_RST = 12'd10;
  localparam logic [RECLASS_W-1:0] RECLASS_RST = 16'd200;
  localparam logic [TAN_W-1:0] LOCAL_TAN_RST = 16'd9210;
  localparam logic [TAN_W-1:0] GENERAL_TAN_RST = 16'd5734;

  typedef struct packed {
    logic [SENSOR_W-1:0] mount_height;
    logic [DIST_W-1:0] min_height;
    logic [DIST_W-1:0] concentric;
    logic [RECLASS_W-1:0] reclass;
    logic [TAN_W-1:0] local_tan;
    logic [TAN_W-1:0] general_tan;
  } cfg_t;

  // History of the previous point of the ray
  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic signed [HEIGHT_W-1:0] height;
    logic ground;
  } hist_t;

endpackage

### rtl/ray_ground_point_classifier.sv
// Top level of the ray ground point classifier: handshake, history and registers.
//
// Input channel: in_valid with radius_mm, height_mm, ray_start, point_index;
// an item is taken at a clock edge where in_valid is high and in_stall low.
// Points of one ray come in order of increasing radius, the first one flagged
// with ray_start. Output channel: out_valid with out_index and is_ground, one
// result per point, taken when out_valid is high and out_stall low.
// The point is held in an input register, classified against the previous
// point in one pass, and written to the result register together with the
// updated ray history. Throughput is one point per cycle while out_stall is
// low; the history update inside that single pass is what sets it.
// When out_stall holds the result, the input register still takes one more
// item, then in_stall rises until the result leaves.
// A synchronous rst empties both registers, clears the history and loads the
// default thresholds. Thresholds are to be written over the APB port only
// while no point is in flight; the block does not enforce this.
module ray_ground_point_classifier (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [rgpc_pkg::RADIUS_W-1:0] radius_mm,
  input  logic signed [rgpc_pkg::HEIGHT_W-1:0] height_mm,
  input  logic ray_start,
  input  logic [rgpc_pkg::INDEX_W-1:0] point_index,
  output logic out_valid,
  input  logic out_stall,
  output logic [rgpc_pkg::INDEX_W-1:0] out_index,
  output logic is_ground,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rgpc_pkg::ADDR_W-1:0] paddr,
  input  logic [rgpc_pkg::DATA_W-1:0] pwdata,
  output logic [rgpc_pkg::DATA_W-1:0] prdata,
  output logic pready
);

  rgpc_pkg::cfg_t cfg;
  rgpc_pkg::hist_t hist;
  rgpc_pkg::hist_t hist_next;

  logic in_full;
  logic [rgpc_pkg::RADIUS_W-1:0] in_radius;
  logic signed [rgpc_pkg::HEIGHT_W-1:0] in_height;
  logic in_start;
  logic [rgpc_pkg::INDEX_W-1:0] in_index;

  logic out_free;
  logic advance;
  logic in_load;

  assign out_free = !out_valid || !out_stall;
  assign advance = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_load = in_valid && !in_stall;

  rgpc_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  rgpc_calc u_calc (
    .cfg(cfg),
    .hist(hist),
    .radius_mm(in_radius),
    .height_mm(in_height),
    .ray_start(in_start),
    .hist_next(hist_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_radius <= radius_mm;
      in_height <= height_mm;
      in_start <= ray_start;
      in_index <= point_index;
    end
  end

  // Advance history only when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (advance) begin
      hist <= hist_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index <= in_index;
      is_ground <= hist_next.ground;
    end
  end

endmodule

### rtl/rgpc_cfg.sv
// APB register bank holding the classifier thresholds.
module rgpc_cfg (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rgpc_pkg::ADDR_W-1:0] paddr,
  input  logic [rgpc_pkg::DATA_W-1:0] pwdata,
  output logic [rgpc_pkg::DATA_W-1:0] prdata,
  output logic pready,
  output rgpc_pkg::cfg_t cfg
);

  logic wr_en;
  logic [2:0] reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mount_height <= rgpc_pkg::MOUNT_HEIGHT_RST;
      cfg.min_height <= rgpc_pkg::MIN_HEIGHT_RST;
      cfg.concentric <= rgpc_pkg::CONCENTRIC_RST;
      cfg.reclass <= rgpc_pkg::RECLASS_RST;
      cfg.local_tan <= rgpc_pkg::LOCAL_TAN_RST;
      cfg.general_tan <= rgpc_pkg::GENERAL_TAN_RST;
    end else if (wr_en) begin
      case (reg_sel)
        rgpc_pkg::REG_MOUNT_HEIGHT: cfg.mount_height <= pwdata[rgpc_pkg::SENSOR_W-1:0];
        rgpc_pkg::REG_MIN_HEIGHT: cfg.min_height <= pwdata[rgpc_pkg::DIST_W-1:0];
        rgpc_pkg::REG_CONCENTRIC: cfg.concentric <= pwdata[rgpc_pkg::DIST_W-1:0];
        rgpc_pkg::REG_RECLASS: cfg.reclass <= pwdata[rgpc_pkg::RECLASS_W-1:0];
        rgpc_pkg::REG_LOCAL_TAN: cfg.local_tan <= pwdata[rgpc_pkg::TAN_W-1:0];
        rgpc_pkg::REG_GENERAL_TAN: cfg.general_tan <= pwdata[rgpc_pkg::TAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      rgpc_pkg::REG_MOUNT_HEIGHT: prdata[rgpc_pkg::SENSOR_W-1:0] = cfg.mount_height;
      rgpc_pkg::REG_MIN_HEIGHT: prdata[rgpc_pkg::DIST_W-1:0] = cfg.min_height;
      rgpc_pkg::REG_CONCENTRIC: prdata[rgpc_pkg::DIST_W-1:0] = cfg.concentric;
      rgpc_pkg::REG_RECLASS: prdata[rgpc_pkg::RECLASS_W-1:0] = cfg.reclass;
      rgpc_pkg::REG_LOCAL_TAN: prdata[rgpc_pkg::TAN_W-1:0] = cfg.local_tan;
      rgpc_pkg::REG_GENERAL_TAN: prdata[rgpc_pkg::TAN_W-1:0] = cfg.general_tan;
      default: prdata = '0;
    endcase
  end

endmodule

### rtl/rgpc_calc.sv
// Ground test of one point against the previous point of its ray.
module rgpc_calc (
  input  rgpc_pkg::cfg_t cfg,
  input  rgpc_pkg::hist_t hist,
  input  logic [rgpc_pkg::RADIUS_W-1:0] radius_mm,
  input  logic signed [rgpc_pkg::HEIGHT_W-1:0] height_mm,
  input  logic ray_start,
  output rgpc_pkg::hist_t hist_next
);

  // Heights are compared in Q16, thresholds are at most 35 bits signed
  localparam int QW = 37;
  localparam int DW = rgpc_pkg::HEIGHT_W + 2;
  localparam int SW = rgpc_pkg::RADIUS_W + 1;
  localparam int LPW = rgpc_pkg::TAN_W + 1 + SW;
  localparam int GPW = rgpc_pkg::TAN_W + rgpc_pkg::RADIUS_W;
  localparam int FW = rgpc_pkg::DIST_W + rgpc_pkg::FRAC_W;

  function automatic logic in_window(input logic signed [DW-1:0] diff,
                                     input logic signed [QW-1:0] thr);
    logic signed [QW-1:0] diff_q;
    begin
      diff_q = {{(QW-DW-rgpc_pkg::FRAC_W){diff[DW-1]}}, diff,
                {rgpc_pkg::FRAC_W{1'b0}}};
      in_window = (diff_q <= thr) && (diff_q >= -thr);
    end
  endfunction

  logic [rgpc_pkg::RADIUS_W-1:0] base_radius;
  logic signed [rgpc_pkg::HEIGHT_W-1:0] sensor_s;
  logic signed [rgpc_pkg::HEIGHT_W-1:0] base_height;
  logic base_ground;
  logic signed [SW-1:0] step;
  logic signed [LPW-1:0] local_prod;
  logic [GPW-1:0] general_prod;
  logic signed [QW-1:0] local_thr;
  logic signed [QW-1:0] floor_thr;
  logic signed [QW-1:0] general_thr;
  logic signed [DW-1:0] d_prev;
  logic signed [DW-1:0] d_gnd;
  logic ground;

  always_comb begin
    sensor_s = $signed({3'b000, cfg.mount_height});
    // A new ray starts from the expected ground under the sensor
    base_radius = ray_start ? '0 : hist.radius;
    base_height = ray_start ? -sensor_s : hist.height;
    base_ground = ray_start ? 1'b0 : hist.ground;

    step = $signed({1'b0, radius_mm}) - $signed({1'b0, base_radius});
    local_prod = LPW'($signed({1'b0, cfg.local_tan})) * LPW'(step);
    general_prod = GPW'(cfg.general_tan) * GPW'(radius_mm);

    local_thr = {{(QW-LPW){local_prod[LPW-1]}}, local_prod};
    floor_thr = $signed({{(QW-FW){1'b0}}, cfg.min_height, {rgpc_pkg::FRAC_W{1'b0}}});
    general_thr = $signed({{(QW-GPW){1'b0}}, general_prod});

    if (step > $signed({{(SW-rgpc_pkg::DIST_W){1'b0}}, cfg.concentric}) &&
        local_thr < floor_thr) begin
      local_thr = floor_thr;
    end

    d_prev = {{2{height_mm[rgpc_pkg::HEIGHT_W-1]}}, height_mm} -
             {{2{base_height[rgpc_pkg::HEIGHT_W-1]}}, base_height};
    d_gnd = {{2{height_mm[rgpc_pkg::HEIGHT_W-1]}}, height_mm} +
            {{2{sensor_s[rgpc_pkg::HEIGHT_W-1]}}, sensor_s};

    if (in_window(d_prev, local_thr)) begin
      ground = base_ground || in_window(d_gnd, general_thr);
    end else begin
      // Reclassify only after a large radius gap
      ground = (step > $signed({{(SW-rgpc_pkg::RECLASS_W){1'b0}}, cfg.reclass})) &&
               in_window(d_gnd, local_thr);
    end

    hist_next.radius = radius_mm;
    hist_next.height = height_mm;
    hist_next.ground = ground;
  end

endmodule
